>>> hdl/nbga_pkg.sv
// ----------------------------------------------------------------------------
// nbga_pkg
// Shared types and constants for the all-pairs gravitational acceleration block.
// ----------------------------------------------------------------------------
package nbga_pkg;

    localparam int MaxBodiesDefault = 64;

    localparam int unsigned GravityReset  = 32'd16777216;
    localparam int unsigned SofteningReset = 32'd65536;

    // Configuration register indexes.
    localparam logic CfgGravity   = 1'b0;
    localparam logic CfgSoftening = 1'b1;

    // Axis selectors for the per-axis term loop.
    localparam logic [1:0] AxisX = 2'd0;
    localparam logic [1:0] AxisY = 2'd1;
    localparam logic [1:0] AxisZ = 2'd2;

    // Per-pair contribution clamp, 2^48.
    localparam logic [48:0] TermLimit = 49'h1_0000_0000_0000;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SOFT,
        S_SOFTW,
        S_RDI,
        S_LDI,
        S_RDJ,
        S_LDJ,
        S_SQX,
        S_SQY,
        S_SQZ,
        S_SUM,
        S_GM,
        S_NORM,
        S_SQRT,
        S_CUBE,
        S_CUBEW,
        S_PLO,
        S_PHI,
        S_PACC,
        S_SHIFT,
        S_DIV,
        S_ACC,
        S_NEXTJ,
        S_OUT
    } t_state;

endpackage

>>> hdl/nbody_gravity_accelerations.sv
// Operation: bodies load one per cycle while the block is idle; after the body
// marked last, each result takes N pair steps, one per loaded body (normalize,
// square root, then a restoring divide per axis), on the one shared divider
// and the single 32x32 multiplier. New bodies are not taken until the last
// result has been sent. Reset is synchronous, active low, and clears the control
// state and the configuration registers; body stores are not cleared.
// ----------------------------------------------------------------------------
// nbody_gravity_accelerations
// Loads bodies into on-chip stores, then computes softened gravitational
// accelerations for every body with one shared multiplier and divider.
// ----------------------------------------------------------------------------
module nbody_gravity_accelerations
    import nbga_pkg::*;
#(
    parameter int MAX_BODIES = MaxBodiesDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write channel.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    // Body input: tdata = pos_x, pos_y, pos_z, body_mass (lowest bits first).
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    // Result output: tdata = body_index[5:0], acc_x, acc_y, acc_z, two zero bits.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam int IW = $clog2(MAX_BODIES);
    localparam int CW = $clog2(MAX_BODIES + 1);

    t_state r_state, n_state;

    logic [31:0] r_gravity;
    logic [31:0] r_soft;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_i, r_j;

    logic [31:0] mem_x [MAX_BODIES];
    logic [31:0] mem_y [MAX_BODIES];
    logic [31:0] mem_z [MAX_BODIES];
    logic [31:0] mem_m [MAX_BODIES];
    logic [31:0] r_rd_x, r_rd_y, r_rd_z, r_rd_m;
    logic [IW-1:0] rd_addr;

    logic [31:0] r_xi, r_yi, r_zi, r_mj;
    logic [31:0] r_ux, r_uy, r_uz;
    logic        r_nx, r_ny, r_nz;

    logic [31:0] mul_a, mul_b;
    logic [63:0] r_prod;
    logic [63:0] r_soft2;
    logic [65:0] r_d2;
    logic [63:0] r_gm;
    logic signed [5:0] r_e;

    logic [61:0] r_sv;
    logic [62:0] r_sres;
    logic [4:0]  r_k;
    logic [60:0] r_cube;

    logic [1:0]   r_axis;
    logic [95:0]  r_p;
    logic [126:0] r_num;
    logic [60:0]  r_rem;
    logic [48:0]  r_q;
    logic [6:0]   r_dcnt;
    logic [48:0]  r_mag;

    logic signed [55:0] r_ax, r_ay, r_az;

    logic in_xfer, out_xfer;
    logic last_j, last_i;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign last_j   = (CW'(r_j) + CW'(1)) == r_cnt;
    assign last_i   = (CW'(r_i) + CW'(1)) == r_cnt;
    assign o_cfg_ready = 1'b1;

    // Current axis operand.
    logic [31:0] u_axis;
    logic        neg_axis;
    always_comb begin
        case (r_axis)
            AxisX:   begin u_axis = r_ux; neg_axis = r_nx; end
            AxisY:   begin u_axis = r_uy; neg_axis = r_ny; end
            AxisZ:   begin u_axis = r_uz; neg_axis = r_nz; end
            default: begin u_axis = r_ux; neg_axis = r_nx; end
        endcase
    end

    // Square root step.
    logic [62:0] sq_bit, sq_sum;
    logic        sq_take;
    assign sq_bit  = 63'(1) << {r_k, 1'b0};
    assign sq_sum  = r_sres + sq_bit;
    assign sq_take = {1'b0, r_sv} >= sq_sum;

    // Numerator alignment.
    logic signed [7:0] e_ext, shift_amt;
    logic [162:0] wide_l;
    logic [126:0] num_r;
    logic         num_ovf;
    assign e_ext     = {{2{r_e[5]}}, r_e};
    assign shift_amt = 8'sd24 - (e_ext + e_ext + e_ext);
    assign wide_l    = {67'b0, r_p} << shift_amt[6:0];
    assign num_r     = {31'b0, r_p} >> 7'(-shift_amt);
    assign num_ovf   = |wide_l[162:127];

    // Divide step. The remainder stays below the divisor, so 61 bits hold it.
    logic [61:0] rem_sh;
    logic        q_bit;
    logic [49:0] q_next;
    assign rem_sh = {r_rem, r_num[126]};
    assign q_bit  = rem_sh >= {1'b0, r_cube};
    assign q_next = {r_q, q_bit};

    // Signed contribution.
    logic signed [55:0] term;
    assign term = neg_axis ? -$signed({7'b0, r_mag}) : $signed({7'b0, r_mag});

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_xfer && s_axis_tlast) n_state = S_SOFT;
            S_SOFT:  n_state = S_SOFTW;
            S_SOFTW: n_state = S_RDI;
            S_RDI:   n_state = S_LDI;
            S_LDI:   n_state = S_RDJ;
            S_RDJ:   n_state = S_LDJ;
            S_LDJ:   n_state = S_SQX;
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_SQZ;
            S_SQZ:   n_state = S_SUM;
            S_SUM:   n_state = S_GM;
            S_GM:    n_state = (r_d2 == '0) ? S_NEXTJ : S_NORM;
            S_NORM:  n_state = (r_d2[65:28] == '0 || r_d2 >= 66'h4000_0000) ? S_NORM
                                                                             : S_SQRT;
            S_SQRT:  if (r_k == '0) n_state = S_CUBE;
            S_CUBE:  n_state = S_CUBEW;
            S_CUBEW: n_state = S_PLO;
            S_PLO:   n_state = S_PHI;
            S_PHI:   n_state = S_PACC;
            S_PACC:  n_state = S_SHIFT;
            S_SHIFT: n_state = (shift_amt >= 0 && num_ovf) ? S_ACC : S_DIV;
            S_DIV:   if (q_next > {1'b0, TermLimit} || r_dcnt == '0) n_state = S_ACC;
            S_ACC:   n_state = (r_axis == AxisZ) ? S_NEXTJ : S_PLO;
            S_NEXTJ: n_state = last_j ? S_OUT : S_RDJ;
            S_OUT:   if (out_xfer) n_state = last_i ? S_IDLE : S_RDI;
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs and multiplier operands.
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        m_axis_tvalid = (r_state == S_OUT);
        rd_addr = (r_state == S_RDI) ? r_i : r_j;
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SOFT:  begin mul_a = r_soft;      mul_b = r_soft; end
            S_SQX:   begin mul_a = r_ux;        mul_b = r_ux; end
            S_SQY:   begin mul_a = r_uy;        mul_b = r_uy; end
            S_SQZ:   begin mul_a = r_uz;        mul_b = r_uz; end
            S_SUM:   begin mul_a = r_gravity;   mul_b = r_mj; end
            S_CUBE:  begin mul_a = {2'b0, r_d2[29:0]}; mul_b = r_sres[31:0]; end
            S_PLO:   begin mul_a = r_gm[31:0];  mul_b = u_axis; end
            S_PHI:   begin mul_a = r_gm[63:32]; mul_b = u_axis; end
            default: begin mul_a = '0;          mul_b = '0; end
        endcase
    end

    // Saturated outputs.
    function automatic logic [31:0] sat32(input logic signed [55:0] v);
        if (v > 56'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        else if (v < -56'sh8000_0000) return 32'h8000_0000;
        else return v[31:0];
    endfunction

    assign m_axis_tdata = {2'b0, sat32(r_az), sat32(r_ay), sat32(r_ax), 6'(r_i)};
    assign m_axis_tlast = last_i;

    // Body stores.
    always_ff @(posedge i_clk) begin
        if (in_xfer && r_cnt < CW'(MAX_BODIES)) begin
            mem_x[r_cnt[IW-1:0]] <= s_axis_tdata[31:0];
            mem_y[r_cnt[IW-1:0]] <= s_axis_tdata[63:32];
            mem_z[r_cnt[IW-1:0]] <= s_axis_tdata[95:64];
            mem_m[r_cnt[IW-1:0]] <= s_axis_tdata[127:96];
        end
        r_rd_x <= mem_x[rd_addr];
        r_rd_y <= mem_y[rd_addr];
        r_rd_z <= mem_z[rd_addr];
        r_rd_m <= mem_m[rd_addr];
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_gravity <= GravityReset;
            r_soft    <= SofteningReset;
            r_cnt     <= '0;
            r_i       <= '0;
            r_j       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == CfgGravity) r_gravity <= i_cfg_data;
                else r_soft <= i_cfg_data;
            end
            if (in_xfer && r_cnt < CW'(MAX_BODIES)) r_cnt <= r_cnt + CW'(1);
            if (r_state == S_IDLE) r_i <= '0;
            if (r_state == S_LDI) r_j <= '0;
            if (r_state == S_NEXTJ && !last_j) r_j <= r_j + IW'(1);
            if (r_state == S_OUT && out_xfer) begin
                if (last_i) r_cnt <= '0;
                else r_i <= r_i + IW'(1);
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            S_SOFTW: r_soft2 <= r_prod;
            S_LDI: begin
                r_xi <= r_rd_x;
                r_yi <= r_rd_y;
                r_zi <= r_rd_z;
                r_ax <= '0;
                r_ay <= '0;
                r_az <= '0;
            end
            S_LDJ: begin
                r_mj <= r_rd_m;
                r_nx <= $signed(r_rd_x) < $signed(r_xi);
                r_ny <= $signed(r_rd_y) < $signed(r_yi);
                r_nz <= $signed(r_rd_z) < $signed(r_zi);
                r_ux <= ($signed(r_rd_x) < $signed(r_xi)) ? r_xi - r_rd_x : r_rd_x - r_xi;
                r_uy <= ($signed(r_rd_y) < $signed(r_yi)) ? r_yi - r_rd_y : r_rd_y - r_yi;
                r_uz <= ($signed(r_rd_z) < $signed(r_zi)) ? r_zi - r_rd_z : r_rd_z - r_zi;
            end
            S_SQY: r_d2 <= {2'b0, r_prod} + {2'b0, r_soft2};
            S_SQZ: r_d2 <= r_d2 + {2'b0, r_prod};
            S_SUM: begin
                r_d2 <= r_d2 + {2'b0, r_prod};
                r_e  <= '0;
            end
            S_GM: r_gm <= r_prod;
            S_NORM: begin
                // Bring the mantissa into [2^28, 2^30) by steps of four.
                if (r_d2 >= 66'h4000_0000) begin
                    r_d2 <= r_d2 >> 2;
                    r_e  <= r_e + 6'sd1;
                end else if (r_d2 < 66'h1000_0000) begin
                    r_d2 <= r_d2 << 2;
                    r_e  <= r_e - 6'sd1;
                end else begin
                    r_sv   <= {r_d2[29:0], 32'b0};
                    r_sres <= '0;
                    r_k    <= 5'd31;
                end
            end
            S_SQRT: begin
                if (sq_take) begin
                    r_sv   <= r_sv - sq_sum[61:0];
                    r_sres <= (r_sres >> 1) + sq_bit;
                end else begin
                    r_sres <= r_sres >> 1;
                end
                r_k <= r_k - 5'd1;
            end
            S_CUBEW: begin
                r_cube <= r_prod[60:0];
                r_axis <= AxisX;
            end
            S_PHI:  r_p <= {32'b0, r_prod};
            S_PACC: r_p <= r_p + {r_prod, 32'b0};
            S_SHIFT: begin
                r_num  <= (shift_amt >= 0) ? wide_l[126:0] : num_r;
                r_rem  <= '0;
                r_q    <= '0;
                r_dcnt <= 7'd126;
                r_mag  <= TermLimit;
            end
            S_DIV: begin
                r_num  <= r_num << 1;
                r_rem  <= q_bit ? 61'(rem_sh - {1'b0, r_cube}) : rem_sh[60:0];
                r_q    <= q_next[48:0];
                r_dcnt <= r_dcnt - 7'd1;
                if (q_next > {1'b0, TermLimit}) r_mag <= TermLimit;
                else if (r_dcnt == '0) r_mag <= q_next[48:0];
            end
            S_ACC: begin
                case (r_axis)
                    AxisX:   r_ax <= r_ax + term;
                    AxisY:   r_ay <= r_ay + term;
                    default: r_az <= r_az + term;
                endcase
                r_axis <= r_axis + 2'd1;
            end
            default: ;
        endcase
    end

endmodule
